// ===== src/tfn_pkg.sv =====
// tfn_pkg: shared widths and a bit-length function for the triangle face normal block
// no dependencies
package tfn_pkg;

  localparam int COORD_WIDTH_DEF      = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int SCALE_BITS           = 30;
  localparam int SQ_WIDTH             = 2 * SCALE_BITS + 2;

  // bit length of the low w bits of a value, scanned from the bottom
  function automatic int unsigned bitlen(input logic [127:0] v, input int unsigned w);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 128; i++) begin
      if (i < w && v[i]) n = i + 1;
    end
    return n;
  endfunction

endpackage

// ===== src/tfn_if.sv =====
// tfn_if: valid/ready channel carrying a payload of type payload_t
// no dependencies
interface tfn_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/tfn_sqrt_cell.sv =====
// tfn_sqrt_cell: one registered bit of the restoring square-root chain
// uses tfn_pkg; carries the partial root and the remainder
module tfn_sqrt_cell
  import tfn_pkg::*;
#(
  parameter int RW = 32,
  parameter int SW = 64,
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [SW-1:0] rem_in,
  input  logic [RW-1:0] res_in,
  output logic [SW-1:0] rem_out,
  output logic [RW-1:0] res_out
);
  // one restoring square-root bit, res holds the root bits found so far
  logic [SW-1:0] trial;
  logic [SW-1:0] rem_next;
  logic [RW-1:0] res_next;

  always_comb begin
    trial = ({{(SW-RW){1'b0}}, res_in} << (STEP + 1)) | (SW'(1) << (2 * STEP));
    if (rem_in >= trial) begin
      rem_next = rem_in - trial;
      res_next = res_in | (RW'(1) << STEP);
    end else begin
      rem_next = rem_in;
      res_next = res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      res_out <= res_next;
    end
  end
endmodule

// ===== src/tfn_div_cell.sv =====
// tfn_div_cell: one quotient bit of a restoring divider, registered
// uses tfn_pkg
module tfn_div_cell
  import tfn_pkg::*;
#(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_in,
  input  logic [DW-1:0] den,
  input  logic [NW-1:0] q_in,
  output logic [NW-1:0] num_out,
  output logic [NW-1:0] q_out
);
  logic [NW+DW-1:0] shifted;
  logic [NW+DW-1:0] num_w;

  always_comb begin
    num_w   = {{DW{1'b0}}, num_in};
    shifted = {{NW{1'b0}}, den} << STEP;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (num_w >= shifted) begin
        num_out <= NW'(num_w - shifted);
        q_out   <= q_in | (NW'(1) << STEP);
      end else begin
        num_out <= num_in;
        q_out   <= q_in;
      end
    end
  end
endmodule

// ===== src/triangle_face_normal.sv =====
// triangle_face_normal: unit face normal of a triangle, fixed point
// uses tfn_pkg, tfn_if, tfn_sqrt_cell, tfn_div_cell
//
//  channel | dir | payload
//  tri_in  | in  | a_x..c_z, COORD_WIDTH bits signed each
//  nrm_out | out | n_x, n_y, n_z (NORMAL_FRAC_BITS+2 signed), degenerate
//
// one triangle per cycle while the output is not stalled; edge, product, difference, scale and square
// stages, then 31 root cells and NORMAL_FRAC_BITS+2 divide cells in the bit-serial root and divide chains
// the whole chain advances when the output register is empty or being taken
// reset clears only the valid bits of the stages; no state survives an item
module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  tfn_if.sink   tri_in,
  tfn_if.source nrm_out
);
  localparam int EW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * EW;
  localparam int CW  = PW + 1;
  localparam int NWO = NORMAL_FRAC_BITS + 2;
  localparam int RW  = SCALE_BITS + 1;
  localparam int NRB = RW;
  localparam int DNW = SCALE_BITS + NORMAL_FRAC_BITS + 1;
  localparam int NQB = NORMAL_FRAC_BITS + 2;
  localparam int DEPTH = 5 + NRB + NQB;

  logic en;
  logic [DEPTH-1:0] vld;
  assign en = !vld[DEPTH-1] || nrm_out.ready;
  assign tri_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], tri_in.valid};
  end

  // stage 1: edges
  logic signed [EW-1:0] ex, ey, ez, fx, fy, fz;
  always_ff @(posedge clk) begin
    if (en) begin
      ex <= EW'(signed'(tri_in.data.b_x)) - EW'(signed'(tri_in.data.a_x));
      ey <= EW'(signed'(tri_in.data.b_y)) - EW'(signed'(tri_in.data.a_y));
      ez <= EW'(signed'(tri_in.data.b_z)) - EW'(signed'(tri_in.data.a_z));
      fx <= EW'(signed'(tri_in.data.c_x)) - EW'(signed'(tri_in.data.a_x));
      fy <= EW'(signed'(tri_in.data.c_y)) - EW'(signed'(tri_in.data.a_y));
      fz <= EW'(signed'(tri_in.data.c_z)) - EW'(signed'(tri_in.data.a_z));
    end
  end

  // stage 2: products, stage 3: differences
  logic signed [PW-1:0] p [6];
  logic signed [CW-1:0] cr [3];
  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= ey * fz; p[1] <= ez * fy;
      p[2] <= ez * fx; p[3] <= ex * fz;
      p[4] <= ex * fy; p[5] <= ey * fx;
      for (int i = 0; i < 3; i++)
        cr[i] <= CW'(p[2*i]) - CW'(p[2*i+1]);
    end
  end

  // stage 4: scale to the top bit at position SCALE_BITS-1
  logic [CW-1:0] mg [3];
  logic [CW-1:0] orm;
  int unsigned   len;
  logic [RW-1:0] m_s [3];
  logic [2:0]    neg_s;
  logic          deg_s;
  always_comb begin
    for (int i = 0; i < 3; i++) mg[i] = cr[i][CW-1] ? CW'(-cr[i]) : CW'(cr[i]);
    orm = mg[0] | mg[1] | mg[2];
    len = bitlen(128'(orm), CW);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (len < SCALE_BITS) m_s[i] <= RW'(128'(mg[i]) << (SCALE_BITS - len));
        else m_s[i] <= RW'(128'(mg[i]) >> (len - SCALE_BITS));
        neg_s[i] <= cr[i][CW-1];
      end
      deg_s <= (len == 0);
    end
  end

  // sum of squares
  logic [SQ_WIDTH-1:0] sq;
  logic [RW-1:0] m_q [3];
  logic [2:0] neg_q;
  logic deg_q;
  always_ff @(posedge clk) begin
    if (en) begin
      sq <= SQ_WIDTH'(m_s[0] * m_s[0]) + SQ_WIDTH'(m_s[1] * m_s[1])
          + SQ_WIDTH'(m_s[2] * m_s[2]);
      m_q <= m_s; neg_q <= neg_s; deg_q <= deg_s;
    end
  end

  // root chain, side data travels alongside
  logic [SQ_WIDTH-1:0] rrem [NRB+1];
  logic [RW-1:0]       rres [NRB+1];
  logic [RW-1:0]       rm [NRB+1][3];
  logic [2:0]          rneg [NRB+1];
  logic                rdeg [NRB+1];
  assign rrem[0] = sq;
  assign rres[0] = '0;
  assign rm[0] = m_q;
  assign rneg[0] = neg_q;
  assign rdeg[0] = deg_q;

  for (genvar k = 0; k < NRB; k++) begin : g_root
    logic [SQ_WIDTH-1:0] rr;
    logic [RW-1:0] rs;
    tfn_sqrt_cell #(.RW(RW), .SW(SQ_WIDTH), .STEP(NRB-1-k)) u_cell (
      .clk(clk), .en(en), .rem_in(rrem[k]), .res_in(rres[k]),
      .rem_out(rr), .res_out(rs));
    // the cell compares against res<<(step+1) | 1<<2step so res holds root bits
    assign rrem[k+1] = rr;
    assign rres[k+1] = rs;
    always_ff @(posedge clk) begin
      if (en) begin
        rm[k+1] <= rm[k]; rneg[k+1] <= rneg[k]; rdeg[k+1] <= rdeg[k];
      end
    end
  end

  // divide chains: (m<<F + r/2) / r
  logic [RW-1:0]  root;
  assign root = rres[NRB];
  logic [DNW-1:0] dnum [NQB+1][3];
  logic [DNW-1:0] dq   [NQB+1][3];
  logic [RW-1:0]  dden [NQB+1];
  logic [2:0]     dneg [NQB+1];
  logic           ddeg [NQB+1];
  for (genvar i = 0; i < 3; i++) begin : g_init
    assign dnum[0][i] = (DNW'(rm[NRB][i]) << NORMAL_FRAC_BITS) + DNW'(root >> 1);
    assign dq[0][i] = '0;
  end
  assign dden[0] = root;
  assign dneg[0] = rneg[NRB];
  assign ddeg[0] = rdeg[NRB];

  for (genvar k = 0; k < NQB; k++) begin : g_div
    for (genvar i = 0; i < 3; i++) begin : g_lane
      tfn_div_cell #(.NW(DNW), .DW(RW), .STEP(NQB-1-k)) u_cell (
        .clk(clk), .en(en), .num_in(dnum[k][i]), .den(dden[k]), .q_in(dq[k][i]),
        .num_out(dnum[k+1][i]), .q_out(dq[k+1][i]));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dden[k+1] <= dden[k]; dneg[k+1] <= dneg[k]; ddeg[k+1] <= ddeg[k];
      end
    end
  end

  assign nrm_out.valid = vld[DEPTH-1];
  always_comb begin
    logic [NWO-1:0] q [3];
    for (int i = 0; i < 3; i++) begin
      q[i] = NWO'(dq[NQB][i]);
      if (dneg[NQB][i]) q[i] = -q[i];
      if (ddeg[NQB]) q[i] = '0;
    end
    nrm_out.data.n_x = q[0];
    nrm_out.data.n_y = q[1];
    nrm_out.data.n_z = q[2];
    nrm_out.data.degenerate = ddeg[NQB];
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    nrm_out.valid && !nrm_out.ready |=> nrm_out.valid)
    else $error("result dropped while stalled");
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    nrm_out.valid && nrm_out.data.degenerate |-> nrm_out.data.n_x == 0 &&
    nrm_out.data.n_y == 0 && nrm_out.data.n_z == 0)
    else $error("degenerate result not zero");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !nrm_out.valid |-> tri_in.ready)
    else $error("input stalled with empty output");
endmodule
